// File: design/bpb_pkg.sv
package bpb_pkg;

  localparam int INDEX_BITS         = 10;
  localparam int SHORT_HISTORY_BITS = 4;
  localparam int LONG_HISTORY_BITS  = 6;
  localparam int NUM_PRED           = 5;

  // Address widths of the five tables.
  localparam int A0_W = INDEX_BITS;
  localparam int A1_W = INDEX_BITS;
  localparam int A2_W = INDEX_BITS + 1;
  localparam int A3_W = INDEX_BITS + SHORT_HISTORY_BITS;
  localparam int A4_W = INDEX_BITS + LONG_HISTORY_BITS;

  // The clearing sweep covers the deepest table.
  localparam int CLR_W = (A4_W > A3_W) ? ((A4_W > A2_W) ? A4_W : A2_W)
                                       : ((A3_W > A2_W) ? A3_W : A2_W);

  // Lowest branch address bit used for the index.
  localparam int PC_LSB = 3;

  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] CTR_TAKEN = 2'd2;

  typedef struct packed {
    logic [31:0] branch_pc;
    logic        taken;
  } branch_t;

  typedef struct packed {
    logic        pred_last_outcome;
    logic        pred_bimodal;
    logic        pred_one_history;
    logic        pred_short_history;
    logic        pred_long_history;
    logic [4:0]  miss_mask;
    logic [31:0] branch_total;
    logic [31:0] miss_total_last_outcome;
    logic [31:0] miss_total_bimodal;
    logic [31:0] miss_total_one_history;
    logic [31:0] miss_total_short_history;
    logic [31:0] miss_total_long_history;
  } result_t;

  typedef struct packed {
    logic [A0_W-1:0] a0;
    logic [A1_W-1:0] a1;
    logic [A2_W-1:0] a2;
    logic [A3_W-1:0] a3;
    logic [A4_W-1:0] a4;
  } tbl_addr_t;

  typedef struct packed {
    logic       d0;
    logic [1:0] d1;
    logic       d2;
    logic [1:0] d3;
    logic [1:0] d4;
  } tbl_data_t;

  function automatic logic [1:0] train_counter(input logic [1:0] c, input logic t);
    logic [1:0] r;
    r = c;
    if (t) begin
      if (c < CTR_MAX) r = c + 2'd1;
    end else begin
      if (c > 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// File: design/bpb_tables.sv
module bpb_tables (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  bpb_pkg::tbl_addr_t    rd_addr,
  input  logic                  wr_en,
  input  bpb_pkg::tbl_addr_t    wr_addr,
  input  bpb_pkg::tbl_data_t    wr_data,
  output bpb_pkg::tbl_data_t    rd_data,
  output logic                  clearing
);

  typedef logic [bpb_pkg::CLR_W-1:0] clr_cnt_t;

  logic       mem0 [0:(1 << bpb_pkg::A0_W)-1];
  logic [1:0] mem1 [0:(1 << bpb_pkg::A1_W)-1];
  logic       mem2 [0:(1 << bpb_pkg::A2_W)-1];
  logic [1:0] mem3 [0:(1 << bpb_pkg::A3_W)-1];
  logic [1:0] mem4 [0:(1 << bpb_pkg::A4_W)-1];

  clr_cnt_t                  clr_cnt;
  logic                      we;
  bpb_pkg::tbl_addr_t        wa;
  bpb_pkg::tbl_data_t        wd;

  // After reset every table is swept to zero, one entry per cycle in each table.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + clr_cnt_t'(1);
      if (clr_cnt == '1) clearing <= 1'b0;
    end
  end

  always_comb begin
    we = clearing | wr_en;
    if (clearing) begin
      wa.a0 = clr_cnt[bpb_pkg::A0_W-1:0];
      wa.a1 = clr_cnt[bpb_pkg::A1_W-1:0];
      wa.a2 = clr_cnt[bpb_pkg::A2_W-1:0];
      wa.a3 = clr_cnt[bpb_pkg::A3_W-1:0];
      wa.a4 = clr_cnt[bpb_pkg::A4_W-1:0];
      wd    = '0;
    end else begin
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem0[wa.a0] <= wd.d0;
      mem1[wa.a1] <= wd.d1;
      mem2[wa.a2] <= wd.d2;
      mem3[wa.a3] <= wd.d3;
      mem4[wa.a4] <= wd.d4;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.d0 <= mem0[rd_addr.a0];
      rd_data.d1 <= mem1[rd_addr.a1];
      rd_data.d2 <= mem2[rd_addr.a2];
      rd_data.d3 <= mem3[rd_addr.a3];
      rd_data.d4 <= mem4[rd_addr.a4];
    end
  end

endmodule

// File: design/bpb_stats.sv
module bpb_stats (
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  logic                taken,
  input  bpb_pkg::tbl_data_t  rd_data,
  output bpb_pkg::result_t    result_next,
  output bpb_pkg::tbl_data_t  wr_data
);

  logic [31:0]                  branch_cnt;
  logic [31:0]                  miss_cnt      [bpb_pkg::NUM_PRED];
  logic [31:0]                  miss_cnt_next [bpb_pkg::NUM_PRED];
  logic [bpb_pkg::NUM_PRED-1:0] pred;
  logic [bpb_pkg::NUM_PRED-1:0] mask;

  always_comb begin
    pred[0] = rd_data.d0;
    pred[1] = (rd_data.d1 >= bpb_pkg::CTR_TAKEN);
    pred[2] = rd_data.d2;
    pred[3] = (rd_data.d3 >= bpb_pkg::CTR_TAKEN);
    pred[4] = (rd_data.d4 >= bpb_pkg::CTR_TAKEN);
    mask    = pred ^ {bpb_pkg::NUM_PRED{taken}};
    for (int k = 0; k < bpb_pkg::NUM_PRED; k++) begin
      miss_cnt_next[k] = miss_cnt[k] + 32'(mask[k]);
    end
  end

  always_comb begin
    result_next.pred_last_outcome        = pred[0];
    result_next.pred_bimodal             = pred[1];
    result_next.pred_one_history         = pred[2];
    result_next.pred_short_history       = pred[3];
    result_next.pred_long_history        = pred[4];
    result_next.miss_mask                = mask;
    result_next.branch_total             = branch_cnt + 32'd1;
    result_next.miss_total_last_outcome  = miss_cnt_next[0];
    result_next.miss_total_bimodal       = miss_cnt_next[1];
    result_next.miss_total_one_history   = miss_cnt_next[2];
    result_next.miss_total_short_history = miss_cnt_next[3];
    result_next.miss_total_long_history  = miss_cnt_next[4];
  end

  // Trained entries go back to the same addresses that were read.
  always_comb begin
    wr_data.d0 = taken;
    wr_data.d1 = bpb_pkg::train_counter(rd_data.d1, taken);
    wr_data.d2 = taken;
    wr_data.d3 = bpb_pkg::train_counter(rd_data.d3, taken);
    wr_data.d4 = bpb_pkg::train_counter(rd_data.d4, taken);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      branch_cnt <= '0;
      for (int k = 0; k < bpb_pkg::NUM_PRED; k++) miss_cnt[k] <= '0;
    end else if (commit) begin
      branch_cnt <= branch_cnt + 32'd1;
      for (int k = 0; k < bpb_pkg::NUM_PRED; k++) miss_cnt[k] <= miss_cnt_next[k];
    end
  end

endmodule

// File: design/branch_predictor_bank.sv
// Channel  Direction  Word type           Handshake
// branch   in         bpb_pkg::branch_t   branch_valid / branch_ready
// result   out        bpb_pkg::result_t   result_valid / result_ready
//
// Each branch takes a synchronous table read, then the update that writes
// the trained entries back and loads the result. The shared read-modify-write
// of the five tables keeps one branch in flight at a time.
// After reset the tables are swept to zero; no branch is taken during the sweep.
// A stalled result holds only the update cycle; the next branch is accepted
// while a finished result waits.
module branch_predictor_bank (
  input  logic              clk,
  input  logic              rst,
  input  logic              branch_valid,
  output logic              branch_ready,
  input  bpb_pkg::branch_t  branch,
  output logic              result_valid,
  input  logic              result_ready,
  output bpb_pkg::result_t  result
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

  state_t                                    state;
  logic                                      prev_outcome;
  logic [bpb_pkg::SHORT_HISTORY_BITS-1:0]    short_hist;
  logic [bpb_pkg::LONG_HISTORY_BITS-1:0]     long_hist;
  logic                                      held_taken;
  bpb_pkg::tbl_addr_t                        held_addr;
  bpb_pkg::tbl_addr_t                        rd_addr;
  bpb_pkg::tbl_data_t                        rd_data;
  bpb_pkg::tbl_data_t                        wr_data;
  bpb_pkg::result_t                          result_next;
  logic [bpb_pkg::INDEX_BITS-1:0]            idx;
  logic                                      accept;
  logic                                      commit;
  logic                                      clearing;

  assign idx = branch.branch_pc[bpb_pkg::INDEX_BITS+bpb_pkg::PC_LSB-1:bpb_pkg::PC_LSB];

  always_comb begin
    rd_addr.a0 = idx;
    rd_addr.a1 = idx;
    rd_addr.a2 = {idx, prev_outcome};
    rd_addr.a3 = {idx, short_hist};
    rd_addr.a4 = {idx, long_hist};
  end

  assign branch_ready = (state == S_IDLE);
  assign accept       = branch_valid & branch_ready;
  // The update waits only until the output register is free.
  assign commit       = (state == S_LOOK) & (~result_valid | result_ready);

  bpb_tables u_tables (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .wr_en    (commit),
    .wr_addr  (held_addr),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  bpb_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .commit      (commit),
    .taken       (held_taken),
    .rd_data     (rd_data),
    .result_next (result_next),
    .wr_data     (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
      prev_outcome <= 1'b0;
      short_hist   <= '0;
      long_hist    <= '0;
    end else begin
      if (result_valid && result_ready && !commit) result_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (!clearing) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            held_addr  <= rd_addr;
            held_taken <= branch.taken;
            state      <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (commit) begin
            result       <= result_next;
            result_valid <= 1'b1;
            prev_outcome <= held_taken;
            short_hist   <= {short_hist[bpb_pkg::SHORT_HISTORY_BITS-2:0], held_taken};
            long_hist    <= {long_hist[bpb_pkg::LONG_HISTORY_BITS-2:0], held_taken};
            state        <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

// File: design/bpb_checker.sv
module bpb_checker (
  input logic              clk,
  input logic              rst,
  input logic              branch_valid,
  input logic              branch_ready,
  input bpb_pkg::branch_t  branch,
  input logic              result_valid,
  input logic              result_ready,
  input bpb_pkg::result_t  result
);

  logic [bpb_pkg::NUM_PRED-1:0] outcome_seen;

  // Every predictor's miss bit must imply the same actual outcome.
  assign outcome_seen = result.miss_mask ^ {result.pred_long_history,
                                            result.pred_short_history,
                                            result.pred_one_history,
                                            result.pred_bimodal,
                                            result.pred_last_outcome};

  a_reset_blocks_input: assert property (@(posedge clk) rst |=> !branch_ready)
    else $error("branch accepted straight after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    branch_valid && branch_ready |=> !branch_ready)
    else $error("second branch accepted while one is in flight");

  a_mask_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (outcome_seen == '0 || outcome_seen == '1))
    else $error("miss mask disagrees with the predictions");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result word changed or dropped");

endmodule

bind branch_predictor_bank bpb_checker u_bpb_checker (.*);

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LO_DEPTH  = 2 ** bpb_pkg::A0_W;
  localparam int BIM_DEPTH = 2 ** bpb_pkg::A1_W;
  localparam int OH_DEPTH  = 2 ** bpb_pkg::A2_W;
  localparam int SH_DEPTH  = 2 ** bpb_pkg::A3_W;
  localparam int LH_DEPTH  = 2 ** bpb_pkg::A4_W;

  localparam int RANDOM_ITEMS = 800;
  localparam int HOT_BRANCHES = 12;
  localparam int DRAIN_CYCLES = 8;
  // The clearing sweep after reset comes first, then the traffic itself.
  localparam longint CYCLE_LIMIT = 2 ** bpb_pkg::CLR_W + 300000;

  // Keeps its own copy of every table, history and count, and the results
  // that the block still owes.
  class branch_book;
    bit                                   lo_tbl[LO_DEPTH];
    bit [1:0]                             bim_tbl[BIM_DEPTH];
    bit                                   oh_tbl[OH_DEPTH];
    bit [1:0]                             sh_tbl[SH_DEPTH];
    bit [1:0]                             lh_tbl[LH_DEPTH];
    bit                                   prev_taken;
    bit [bpb_pkg::SHORT_HISTORY_BITS-1:0] short_hist;
    bit [bpb_pkg::LONG_HISTORY_BITS-1:0]  long_hist;
    bit [31:0]                            n_branches;
    bit [31:0]                            n_miss[bpb_pkg::NUM_PRED];
    bpb_pkg::result_t                     owed[$];
    int                                   errors;
    int                                   n_checked;

    function bit [1:0] saturate_step(bit [1:0] c, bit t);
      if (t) return (c == bpb_pkg::CTR_MAX) ? c : c + 2'd1;
      return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    function void note_branch(bpb_pkg::branch_t b);
      logic [bpb_pkg::A0_W-1:0]   idx;
      logic [bpb_pkg::A2_W-1:0]   a_oh;
      logic [bpb_pkg::A3_W-1:0]   a_sh;
      logic [bpb_pkg::A4_W-1:0]   a_lh;
      bit [bpb_pkg::NUM_PRED-1:0] guess;
      bit [bpb_pkg::NUM_PRED-1:0] wrong;
      bpb_pkg::result_t           r;
      idx  = b.branch_pc[bpb_pkg::PC_LSB +: bpb_pkg::INDEX_BITS];
      a_oh = {idx, prev_taken};
      a_sh = {idx, short_hist};
      a_lh = {idx, long_hist};
      guess[0] = lo_tbl[idx];
      guess[1] = bim_tbl[idx] >= bpb_pkg::CTR_TAKEN;
      guess[2] = oh_tbl[a_oh];
      guess[3] = sh_tbl[a_sh] >= bpb_pkg::CTR_TAKEN;
      guess[4] = lh_tbl[a_lh] >= bpb_pkg::CTR_TAKEN;
      n_branches = n_branches + 32'd1;
      wrong = '0;
      for (int k = 0; k < bpb_pkg::NUM_PRED; k++) begin
        if (guess[k] != b.taken) begin
          wrong[k] = 1'b1;
          n_miss[k] = n_miss[k] + 32'd1;
        end
      end
      lo_tbl[idx]  = b.taken;
      bim_tbl[idx] = saturate_step(bim_tbl[idx], b.taken);
      oh_tbl[a_oh] = b.taken;
      sh_tbl[a_sh] = saturate_step(sh_tbl[a_sh], b.taken);
      lh_tbl[a_lh] = saturate_step(lh_tbl[a_lh], b.taken);
      prev_taken = b.taken;
      short_hist = {short_hist[bpb_pkg::SHORT_HISTORY_BITS-2:0], b.taken};
      long_hist  = {long_hist[bpb_pkg::LONG_HISTORY_BITS-2:0], b.taken};
      r.pred_last_outcome        = guess[0];
      r.pred_bimodal             = guess[1];
      r.pred_one_history         = guess[2];
      r.pred_short_history       = guess[3];
      r.pred_long_history        = guess[4];
      r.miss_mask                = wrong;
      r.branch_total             = n_branches;
      r.miss_total_last_outcome  = n_miss[0];
      r.miss_total_bimodal       = n_miss[1];
      r.miss_total_one_history   = n_miss[2];
      r.miss_total_short_history = n_miss[3];
      r.miss_total_long_history  = n_miss[4];
      owed.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                  n_checked, name, got, want));
    endtask

    task check_result(bpb_pkg::result_t got);
      bpb_pkg::result_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with none owed", n_checked));
        n_checked++;
        return;
      end
      want = owed.pop_front();
      compare_field("pred_last_outcome", 32'(got.pred_last_outcome),
                    32'(want.pred_last_outcome));
      compare_field("pred_bimodal", 32'(got.pred_bimodal), 32'(want.pred_bimodal));
      compare_field("pred_one_history", 32'(got.pred_one_history),
                    32'(want.pred_one_history));
      compare_field("pred_short_history", 32'(got.pred_short_history),
                    32'(want.pred_short_history));
      compare_field("pred_long_history", 32'(got.pred_long_history),
                    32'(want.pred_long_history));
      compare_field("miss_mask", 32'(got.miss_mask), 32'(want.miss_mask));
      compare_field("branch_total", got.branch_total, want.branch_total);
      compare_field("miss_total_last_outcome", got.miss_total_last_outcome,
                    want.miss_total_last_outcome);
      compare_field("miss_total_bimodal", got.miss_total_bimodal, want.miss_total_bimodal);
      compare_field("miss_total_one_history", got.miss_total_one_history,
                    want.miss_total_one_history);
      compare_field("miss_total_short_history", got.miss_total_short_history,
                    want.miss_total_short_history);
      compare_field("miss_total_long_history", got.miss_total_long_history,
                    want.miss_total_long_history);
      n_checked++;
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             branch_valid = 1'b0;
  logic             branch_ready;
  bpb_pkg::branch_t branch = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  bpb_pkg::result_t result;

  branch_book book;
  bit         calm;
  bit         traffic_on;
  longint     cycles;

  bit [31:0] hot_pc[HOT_BRANCHES];
  int        hot_period[HOT_BRANCHES];
  int        hot_count[HOT_BRANCHES];

  branch_predictor_bank i_dut (
    .clk          (clk),
    .rst          (rst),
    .branch_valid (branch_valid),
    .branch_ready (branch_ready),
    .branch       (branch),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly back to back, now and then a short pause, rarely a long one.
  function int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (calm || r < 60) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(4, 30));
  endfunction

  task send_branch(bit [31:0] pc, bit t);
    int               gap;
    bpb_pkg::branch_t b;
    gap = pick_gap();
    if (gap > 0) begin
      branch_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    b.branch_pc = pc;
    b.taken     = t;
    branch       <= b;
    branch_valid <= 1'b1;
    do @(posedge clk); while (!branch_ready);
    book.note_branch(b);
  endtask

  // A loop-like branch: taken except on the last pass of its period,
  // with an occasional flip to upset the counters.
  task send_hot(int h);
    bit t;
    t = (hot_count[h] % hot_period[h]) != hot_period[h] - 1;
    if ($urandom_range(0, 9) == 0) t = ~t;
    hot_count[h]++;
    send_branch(hot_pc[h], t);
  endtask

  initial begin
    int gap;
    wait (traffic_on);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      book.check_result(result);
    end
  end

  initial begin
    int h;
    int burst;
    book = new;
    cycles = 0;
    calm = 1'b0;
    traffic_on = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    traffic_on = 1'b1;

    // Address extremes.
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    // Drive one counter up past saturation, down past zero, then back.
    repeat (4) send_branch(32'h0000_1000, 1'b1);
    repeat (4) send_branch(32'h0000_1000, 1'b0);
    send_branch(32'h0000_1000, 1'b1);
    // These share an index with the branch above: low bits and high bits differ.
    send_branch(32'h0000_1007, 1'b1);
    send_branch(32'h8000_1000, 1'b0);
    send_branch(32'h0000_3000, 1'b1);
    // Alternating outcome so the history tables see both halves.
    for (int i = 0; i < 6; i++) send_branch(32'h0000_0040, i[0] == 1'b0);

    for (int i = 0; i < HOT_BRANCHES; i++) begin
      hot_pc[i]     = $urandom();
      hot_period[i] = int'($urandom_range(2, 7));
      hot_count[i]  = 0;
    end

    for (int n = 0; n < RANDOM_ITEMS; n += burst) begin
      if (n % 100 < 10) calm = (n / 100) % 3 == 1;
      if ($urandom_range(0, 3) == 0) begin
        burst = 1;
        send_branch($urandom(), 1'($urandom_range(0, 1)));
      end else begin
        h = int'($urandom_range(0, HOT_BRANCHES - 1));
        burst = int'($urandom_range(1, 10));
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 3) == 0) send_hot(int'($urandom_range(0, HOT_BRANCHES - 1)));
          else send_hot(h);
        end
      end
    end
    branch_valid <= 1'b0;

    while (book.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
